FILE: design/sixsd_pkg.sv
// Shared constants for the sixel stream decoder: stream codes, modes and color math.
package sixsd_pkg;

    // Palette storage
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = 8;

    // Item modes
    localparam logic [1:0] MODE_DATA   = 2'd0;
    localparam logic [1:0] MODE_PALWR  = 2'd1;
    localparam logic [1:0] MODE_NEWIMG = 2'd2;

    // Parser modes
    localparam logic [1:0] PM_DATA   = 2'd0;
    localparam logic [1:0] PM_REPEAT = 2'd1;
    localparam logic [1:0] PM_COLOR  = 2'd2;

    // Stream codes (7-bit)
    localparam logic [6:0] CH_REPEAT  = 7'd33;
    localparam logic [6:0] CH_COLOR   = 7'd35;
    localparam logic [6:0] CH_CR      = 7'd36;
    localparam logic [6:0] CH_NL      = 7'd45;
    localparam logic [6:0] CH_DIGIT0  = 7'd48;
    localparam logic [6:0] CH_DIGIT9  = 7'd57;
    localparam logic [6:0] CH_SEMI    = 7'd59;
    localparam logic [6:0] CH_SIXEL_LO = 7'd63;
    localparam logic [6:0] CH_SIXEL_HI = 7'd126;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_PALUSED = 2'd2;

    // Color kinds in a '#' definition
    localparam logic [15:0] KIND_HLS = 16'd1;
    localparam logic [15:0] KIND_RGB = 16'd2;

    // Percent to byte: q / 100 as (q * ceil(2^19 / 100)) >> 19, exact for q <= 25500
    localparam logic [6:0]  PCT_DIV   = 7'd100;
    localparam logic [12:0] PCT_RECIP = 13'd5243;
    // Hue level: num * 255 / 600000 = ((num * 17) >> 6) / 625, the last step as
    // (m * ceil(2^27 / 625)) >> 27, exact for m < 338080
    localparam logic [17:0] HUE_RECIP = 18'd214749;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

FILE: design/sixel_stream_decoder.sv
// Sixel stream decoder top level: parser, palette memory and span command output.
// Flow: a plain item is latched while idle and then executed from the latch; the execute
// step loads any span or image-end result into the output register, holding while the
// output is stalled. No new item is taken until the last is done; a colour request first
// reduces the index, then reads the palette or defines a colour, and then re-executes.
// Reset: synchronous, clears parser, cursor, colour and output valid, configuration to defaults;
// palette is not cleared.
module sixel_stream_decoder
    import sixsd_pkg::*;
#(
    parameter int MAX_WIDTH   = 2048,
    parameter int PARAM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_pal_index,
    input  logic [31:0] i_pal_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_x_start,
    output logic [10:0] o_band_row,
    output logic [11:0] o_run_length,
    output logic [5:0]  o_sixel_mask,
    output logic [31:0] o_paint_color,
    output logic        o_image_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int CW = $clog2(PARAM_SLOTS + 1);
    localparam int SW = $clog2(PARAM_SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_RDW   = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;
    localparam logic [2:0] S_CWAIT = 3'd6;

    // configuration
    logic [11:0] r_width, r_height;
    logic [8:0]  r_palused;

    // latched transaction
    logic [1:0]  r_mode;
    logic [6:0]  r_code;
    logic [7:0]  r_pidx;
    logic [31:0] r_pval;

    // parser state
    logic [2:0]  r_state, n_state;
    logic [15:0] r_params [PARAM_SLOTS];
    logic [15:0] n_params [PARAM_SLOTS];
    logic [CW-1:0] r_count, n_count;
    logic [1:0]  r_pmode, n_pmode;
    logic [31:0] r_color, n_color;
    logic [15:0] r_cursor, n_cursor;
    logic [11:0] r_band, n_band;
    logic        r_finished, n_finished;

    // index reduction
    logic [8:0]  r_rem, n_rem;
    logic [3:0]  r_kbit, n_kbit;

    // palette memory
    logic [31:0] r_pal [PAL_DEPTH];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [PAL_AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    // output register
    logic        r_out_valid, n_out_valid;
    logic        out_load;
    logic [10:0] r_ox, n_ox, r_oband, n_oband;
    logic [11:0] r_orun, n_orun;
    logic [5:0]  r_omask, n_omask;
    logic [31:0] r_ocolor, n_ocolor;
    logic        r_oend, n_oend;

    // color unit
    logic        clr_start, clr_done;
    logic [31:0] clr_color;

    // decode helpers
    logic [15:0] eff_w;
    logic [11:0] eff_h;
    logic [8:0]  eff_p;
    logic        active, out_free, is_digit, is_sixel;
    logic [SW-1:0] slot;
    logic [CW-1:0] cnt_m1;
    logic [19:0] digit_acc;
    logic [15:0] run_n, span, room;
    logic [16:0] nx;
    logic [5:0]  mask;
    logic        emit, req_ok, req_need;
    logic [15:0] p0;
    logic [9:0]  rem_sh;
    logic [11:0] band_next;

    always_comb begin
        if (r_width == 12'd0) eff_w = 16'd1;
        else if (16'(r_width) > 16'(MAX_WIDTH)) eff_w = 16'(MAX_WIDTH);
        else eff_w = 16'(r_width);
        if (r_height == 12'd0) eff_h = 12'd1;
        else if (r_height > 12'd2048) eff_h = 12'd2048;
        else eff_h = r_height;
        if (r_palused == 9'd0) eff_p = 9'd1;
        else if (r_palused > 9'(PAL_DEPTH)) eff_p = 9'(PAL_DEPTH);
        else eff_p = r_palused;
    end

    always_comb begin
        active    = !r_finished && (r_band < eff_h);
        out_free  = !r_out_valid || !i_out_stall;
        is_digit  = (r_code >= CH_DIGIT0) && (r_code <= CH_DIGIT9);
        is_sixel  = (r_code >= CH_SIXEL_LO) && (r_code <= CH_SIXEL_HI);
        cnt_m1    = r_count - CW'(1);
        slot      = cnt_m1[SW-1:0];
        digit_acc = 20'(r_params[slot]) * 20'd10 + 20'(r_code - CH_DIGIT0);
        p0        = r_params[0];
        mask      = 6'(r_code - CH_SIXEL_LO);
        run_n     = (r_pmode == PM_REPEAT) ? p0 : 16'd1;
        nx        = 17'(r_cursor) + 17'(run_n);
        room      = eff_w - r_cursor;
        span      = (run_n > room) ? room : run_n;
        emit      = (mask != 6'd0) && (run_n != 16'd0) && (r_cursor < eff_w);
        req_ok    = ((r_params[1] == KIND_HLS) ? (r_params[2] <= 16'd360)
                                               : (r_params[2] <= 16'd100))
                    && (r_params[3] <= 16'd100) && (r_params[4] <= 16'd100);
        req_need  = (r_count == CW'(1)) || ((r_count == CW'(5)) && req_ok);
        rem_sh    = {r_rem, p0[r_kbit]};
        band_next = r_band + 12'd6;
    end

    always_comb begin
        n_state     = r_state;
        n_params    = r_params;
        n_count     = r_count;
        n_pmode     = r_pmode;
        n_color     = r_color;
        n_cursor    = r_cursor;
        n_band      = r_band;
        n_finished  = r_finished;
        n_rem       = r_rem;
        n_kbit      = r_kbit;
        n_out_valid = r_out_valid && i_out_stall;
        out_load    = 1'b0;
        n_ox        = 11'd0;
        n_oband     = 11'd0;
        n_orun      = 12'd0;
        n_omask     = 6'd0;
        n_ocolor    = 32'd0;
        n_oend      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_pidx;
        mem_wdata   = r_pval;
        clr_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (r_mode == MODE_PALWR) begin
                    mem_we = 1'b1;
                end else if (r_mode == MODE_NEWIMG) begin
                    for (int i = 0; i < PARAM_SLOTS; i++) n_params[i] = 16'd0;
                    n_count    = CW'(1);
                    n_pmode    = PM_DATA;
                    n_color    = 32'd0;
                    n_cursor   = 16'd0;
                    n_band     = 12'd0;
                    n_finished = 1'b0;
                end else if (r_mode == MODE_DATA && active) begin
                    if (is_digit) begin
                        n_params[slot] = (digit_acc > 20'd65535) ? 16'hFFFF : digit_acc[15:0];
                    end else if ((is_sixel || r_code == CH_REPEAT || r_code == CH_COLOR)
                                 && r_pmode == PM_COLOR) begin
                        // pending colour request is resolved first, then re-executed
                        if (req_need) begin
                            n_rem   = 9'd0;
                            n_kbit  = 4'd15;
                            n_state = S_MOD;
                        end else begin
                            n_pmode = PM_DATA;
                            n_state = S_EXEC;
                        end
                    end else if (is_sixel) begin
                        if (emit && !out_free) begin
                            n_state = S_EXEC;
                        end else begin
                            n_cursor = nx[16] ? 16'hFFFF : nx[15:0];
                            n_pmode  = PM_DATA;
                            if (emit) begin
                                out_load    = 1'b1;
                                n_out_valid = 1'b1;
                                n_ox        = r_cursor[10:0];
                                n_oband     = r_band[10:0];
                                n_orun      = span[11:0];
                                n_omask     = mask;
                                n_ocolor    = r_color;
                            end
                        end
                    end else if (r_code == CH_REPEAT || r_code == CH_COLOR) begin
                        n_params[0] = 16'd0;
                        n_count     = CW'(1);
                        n_pmode     = (r_code == CH_REPEAT) ? PM_REPEAT : PM_COLOR;
                    end else if (r_code == CH_CR) begin
                        n_cursor = 16'd0;
                    end else if (r_code == CH_NL) begin
                        if (band_next >= eff_h && !out_free) begin
                            n_state = S_EXEC;
                        end else begin
                            n_cursor = 16'd0;
                            n_band   = band_next;
                            if (band_next >= eff_h) begin
                                n_finished  = 1'b1;
                                out_load    = 1'b1;
                                n_out_valid = 1'b1;
                                n_oend      = 1'b1;
                            end
                        end
                    end else if (r_code == CH_SEMI) begin
                        if (r_count < CW'(PARAM_SLOTS)) begin
                            n_params[r_count[SW-1:0]] = 16'd0;
                            n_count = r_count + CW'(1);
                        end
                    end
                end
            end
            S_MOD: begin
                // one quotient bit per cycle of param0 mod palette size
                n_rem  = (rem_sh >= {1'b0, eff_p}) ? 9'(rem_sh - {1'b0, eff_p})
                                                   : rem_sh[8:0];
                n_kbit = r_kbit - 4'd1;
                if (r_kbit == 4'd0) begin
                    if (r_count == CW'(5) &&
                        (r_params[1] == KIND_HLS || r_params[1] == KIND_RGB)) begin
                        n_state = S_CLR;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_RDW;
            S_RDW: begin
                n_color = r_rdata;
                n_pmode = PM_DATA;
                n_state = S_EXEC;
            end
            S_CLR: begin
                clr_start = 1'b1;
                n_state   = S_CWAIT;
            end
            S_CWAIT: begin
                if (clr_done) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rem[PAL_AW-1:0];
                    mem_wdata = clr_color;
                    n_color   = clr_color;
                    n_pmode   = PM_DATA;
                    n_state   = S_EXEC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CW'(1);
            r_pmode     <= PM_DATA;
            r_color     <= 32'd0;
            r_cursor    <= 16'd0;
            r_band      <= 12'd0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= 12'd2048;
            r_height    <= 12'd2048;
            r_palused   <= 9'd256;
            for (int i = 0; i < PARAM_SLOTS; i++) r_params[i] <= 16'd0;
        end else begin
            r_state     <= n_state;
            r_params    <= n_params;
            r_count     <= n_count;
            r_pmode     <= n_pmode;
            r_color     <= n_color;
            r_cursor    <= n_cursor;
            r_band      <= n_band;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:   r_width   <= i_cfg_data;
                    CFG_HEIGHT:  r_height  <= i_cfg_data;
                    CFG_PALUSED: r_palused <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_kbit <= n_kbit;
        if (r_state == S_IDLE && i_in_valid) begin
            r_mode <= i_mode;
            r_code <= i_data_byte[6:0];
            r_pidx <= i_pal_index;
            r_pval <= i_pal_value;
        end
        if (out_load) begin
            r_ox     <= n_ox;
            r_oband  <= n_oband;
            r_orun   <= n_orun;
            r_omask  <= n_omask;
            r_ocolor <= n_ocolor;
            r_oend   <= n_oend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_pal[mem_waddr] <= mem_wdata;
        r_rdata <= r_pal[r_rem[PAL_AW-1:0]];
    end

    sixsd_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (clr_start),
        .i_hls   (r_params[1] == KIND_HLS),
        .i_a     (r_params[2][8:0]),
        .i_b     (r_params[3][6:0]),
        .i_c     (r_params[4][6:0]),
        .o_done  (clr_done),
        .o_color (clr_color)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_x_start     = r_ox;
    assign o_band_row    = r_oband;
    assign o_run_length  = r_orun;
    assign o_sixel_mask  = r_omask;
    assign o_paint_color = r_ocolor;
    assign o_image_end   = r_oend;

endmodule

FILE: design/sixsd_color.sv
// Iterative color converter: RGB percentages or HLS (hue in degrees, lightness and saturation in percent) to RGBA8888.
module sixsd_color
    import sixsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_hls,
    input  logic [8:0]  i_a,
    input  logic [6:0]  i_b,
    input  logic [6:0]  i_c,
    output logic        o_done,
    output logic [31:0] o_color
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_PREP = 3'd1;
    localparam logic [2:0] C_NUM  = 3'd2;
    localparam logic [2:0] C_DIV  = 3'd3;
    localparam logic [2:0] C_DONE = 3'd4;

    logic [2:0]  r_state, n_state;
    logic        r_hls, r_rgb;
    logic [8:0]  r_a;
    logic [6:0]  r_b, r_c;
    logic [14:0] r_t1, r_t2;
    logic [8:0]  r_hh;
    logic [1:0]  r_ch;
    logic [17:0] r_val;
    logic [7:0]  r_red, r_grn, r_blu;

    // prep arithmetic
    logic [14:0] t1_c, t2_c;
    logic [9:0]  hsum;
    // channel numerator
    logic [9:0]  a0, a2;
    logic [8:0]  ang;
    logic [6:0]  fac, chv;
    logic signed [15:0] diff;
    logic signed [23:0] prod, num24;
    logic [19:0] t1_60, t2_60, num;
    logic [14:0] pct_q;
    logic [23:0] hue_m;
    logic [17:0] val_c;
    // quotient step
    logic [27:0] pct_prod;
    logic [7:0]  pct_w;
    logic [6:0]  pct_r;
    logic [35:0] hue_prod;
    logic [7:0]  byte_v;
    logic        up;

    always_comb begin
        if (r_b < 7'd50) begin
            t1_c = 15'(r_b * (8'd100 + {1'b0, r_c}));
        end else begin
            t1_c = 15'(r_b * (8'd100 - {1'b0, r_c})) + 15'(14'd100 * r_c);
        end
        t2_c = 15'(16'(r_b) * 16'd200 - 16'(t1_c));
        hsum = {1'b0, r_a} + 10'd240;
    end

    always_comb begin
        a0 = {1'b0, r_hh} + 10'd120;
        if (a0 >= 10'd360) a0 = a0 - 10'd360;
        a2 = {1'b0, r_hh} + 10'd240;
        if (a2 >= 10'd360) a2 = a2 - 10'd360;
        case (r_ch)
            2'd0:    ang = a0[8:0];
            2'd1:    ang = r_hh;
            default: ang = a2[8:0];
        endcase
        fac   = (ang < 9'd60) ? ang[6:0] : 7'(9'd240 - ang);
        diff  = $signed({1'b0, r_t1}) - $signed({1'b0, r_t2});
        prod  = 24'(diff * $signed({1'b0, fac}));
        t1_60 = 20'(r_t1 * 6'd60);
        t2_60 = 20'(r_t2 * 6'd60);
        num24 = $signed({4'b0, t2_60}) + prod;
        if (ang < 9'd60 || (ang >= 9'd180 && ang < 9'd240)) begin
            num = num24[19:0];
        end else if (ang < 9'd180) begin
            num = t1_60;
        end else begin
            num = t2_60;
        end
        case (r_ch)
            2'd0:    chv = r_hls ? r_b : r_a[6:0];
            2'd1:    chv = r_b;
            default: chv = r_hls ? r_b : r_c;
        endcase
        pct_q = {chv, 8'd0} - 15'(chv);
        // num * 17, then drop the factor 64 of the 40000 divisor
        hue_m = {num, 4'd0} + 24'(num);
        val_c = r_rgb ? 18'(pct_q) : hue_m[23:6];
    end

    always_comb begin
        pct_prod = 28'(r_val[14:0]) * 28'(PCT_RECIP);
        pct_w    = pct_prod[26:19];
        pct_r    = 7'(r_val[14:0] - 15'({7'd0, pct_w} * 15'(PCT_DIV)));
        hue_prod = 36'(r_val) * 36'(HUE_RECIP);
        up       = (pct_r > 7'd50) || (pct_r == 7'd50 && pct_w[0]);
        byte_v   = r_rgb ? pct_w + {7'd0, up} : hue_prod[34:27];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = C_PREP;
            C_PREP: n_state = C_NUM;
            C_NUM:  n_state = C_DIV;
            C_DIV:  n_state = (r_ch == 2'd2) ? C_DONE : C_NUM;
            C_DONE: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_hls <= i_hls;
            r_rgb <= !i_hls || (i_c == 7'd0);
            r_a   <= i_a;
            r_b   <= i_b;
            r_c   <= i_c;
            r_ch  <= 2'd0;
        end
        if (r_state == C_PREP) begin
            r_t1 <= t1_c;
            r_t2 <= t2_c;
            r_hh <= (hsum >= 10'd360) ? 9'(hsum - 10'd360) : hsum[8:0];
        end
        if (r_state == C_NUM) begin
            r_val <= val_c;
        end
        if (r_state == C_DIV) begin
            case (r_ch)
                2'd0:    r_red <= byte_v;
                2'd1:    r_grn <= byte_v;
                default: r_blu <= byte_v;
            endcase
            r_ch <= r_ch + 2'd1;
        end
    end

    assign o_done  = (r_state == C_DONE);
    assign o_color = {ALPHA_OPAQUE, r_blu, r_grn, r_red};

endmodule

FILE: dv/sixel_stream_decoder_tb.sv
// Self-checking testbench for the sixel stream decoder: stimulus, span predictor, checker.
module sixel_stream_decoder_tb;
    import sixsd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  dbyte;
        logic [7:0]  idx;
        logic [31:0] val;
    } stream_item_t;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] row;
        logic [11:0] run;
        logic [5:0]  mask;
        logic [31:0] color;
        logic        iend;
    } span_cmd_t;

    typedef struct packed {
        stream_item_t item;
        logic         typed;
        span_cmd_t    span;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_mode = MODE_DATA;
    logic [7:0]  i_data_byte = 8'd0;
    logic [7:0]  i_pal_index = 8'd0;
    logic [31:0] i_pal_value = 32'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [10:0] o_x_start;
    logic [10:0] o_band_row;
    logic [11:0] o_run_length;
    logic [5:0]  o_sixel_mask;
    logic [31:0] o_paint_color;
    logic        o_image_end;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_WIDTH;
    logic [11:0] i_cfg_data = 12'd0;

    sixel_stream_decoder uut (.*);

    always #1 i_clk = ~i_clk;

    // Decoder state mirror
    logic [31:0] pal_mem [PAL_DEPTH];
    int unsigned prm [8];
    int unsigned prm_cnt;
    logic [1:0]  parse_state;
    logic [31:0] cur_color;
    int unsigned cursor;
    int unsigned band_top;
    bit          img_done;
    int unsigned reg_width = 2048, reg_height = 2048, reg_palused = 256;

    stim_row_t   stim_q [$];
    span_cmd_t   span_q [$];
    stim_row_t   cur_row;
    int          errors = 0;
    int          items_in = 0, spans_out = 0, image_ends = 0, color_defs = 0;
    int          send_pct = 0, recv_pct = 0, phase_id = 0;
    int          cycles = 0;

    task automatic report(input string what);
        $display("MISMATCH @%0d: %s", cycles, what);
        errors++;
    endtask

    function automatic int unsigned eff_w();
        if (reg_width == 0) return 1;
        return reg_width > 2048 ? 2048 : reg_width;
    endfunction

    function automatic int unsigned eff_h();
        if (reg_height == 0) return 1;
        return reg_height > 2048 ? 2048 : reg_height;
    endfunction

    function automatic int unsigned eff_pal();
        if (reg_palused == 0) return 1;
        return reg_palused > PAL_DEPTH ? PAL_DEPTH : reg_palused;
    endfunction

    function automatic logic [7:0] pct_to_byte(input int unsigned v);
        int unsigned q, w, r;
        q = v * 255;
        w = q / 100;
        r = q % 100;
        if (r > 50 || (r == 50 && w[0])) w++;
        return w[7:0];
    endfunction

    function automatic logic [31:0] rgb_pack(input int unsigned r, g, b);
        return {ALPHA_OPAQUE, pct_to_byte(b), pct_to_byte(g), pct_to_byte(r)};
    endfunction

    function automatic logic [7:0] hue_level(input longint unsigned t1, t2,
                                             input int unsigned c);
        longint unsigned num;
        if (c < 60) num = t2 * 60 + (t1 - t2) * c;
        else if (c < 180) num = t1 * 60;
        else if (c < 240) num = t2 * 60 + (t1 - t2) * (240 - c);
        else num = t2 * 60;
        return 8'((num * 255) / 600000);
    endfunction

    function automatic logic [31:0] hls_pack(input int unsigned h, l, s);
        longint unsigned t1, t2;
        int unsigned hh;
        if (s == 0) return rgb_pack(l, l, l);
        hh = (h + 240) % 360;
        t1 = (l < 50) ? longint'(l) * (100 + s) : longint'(l) * (100 - s) + 100 * longint'(s);
        t2 = 200 * longint'(l) - t1;
        return {ALPHA_OPAQUE, hue_level(t1, t2, (hh + 240) % 360),
                hue_level(t1, t2, hh), hue_level(t1, t2, (hh + 120) % 360)};
    endfunction

    function automatic void apply_color_request();
        int unsigned slot;
        bit ok;
        slot = prm[0] % eff_pal();
        if (prm_cnt == 1) begin
            cur_color = pal_mem[slot];
        end else if (prm_cnt == 5) begin
            ok = (prm[1] == KIND_HLS ? prm[2] <= 360 : prm[2] <= 100)
                 && prm[3] <= 100 && prm[4] <= 100;
            if (ok) begin
                if (prm[1] == KIND_HLS) pal_mem[slot] = hls_pack(prm[2], prm[3], prm[4]);
                else if (prm[1] == KIND_RGB) pal_mem[slot] = rgb_pack(prm[2], prm[3], prm[4]);
                cur_color = pal_mem[slot];
            end
        end
    endfunction

    function automatic bit paint_span(input int unsigned mask, input int unsigned n,
                                      output span_cmd_t sp);
        int unsigned w, x0, nx;
        w = eff_w();
        x0 = cursor;
        nx = x0 + n;
        cursor = nx > 65535 ? 65535 : nx;
        sp = '0;
        if (mask == 0 || n == 0 || x0 >= w) return 0;
        if (n > w - x0) n = w - x0;
        sp.x = x0[10:0];
        sp.row = band_top[10:0];
        sp.run = n[11:0];
        sp.mask = mask[5:0];
        sp.color = cur_color;
        return 1;
    endfunction

    function automatic void restart_image();
        foreach (prm[i]) prm[i] = 0;
        prm_cnt = 1;
        parse_state = PM_DATA;
        cur_color = 32'd0;
        cursor = 0;
        band_top = 0;
        img_done = 0;
    endfunction

    function automatic bit decode_item(input stream_item_t it, output span_cmd_t sp);
        logic [6:0] code;
        int unsigned slot, p;
        bit has;
        sp = '0;
        has = 0;
        code = it.dbyte[6:0];
        if (it.mode == MODE_PALWR) begin
            pal_mem[it.idx] = it.val;
        end else if (it.mode == MODE_NEWIMG) begin
            restart_image();
        end else if (it.mode == MODE_DATA && !img_done && band_top < eff_h()) begin
            slot = (prm_cnt >= 1 && prm_cnt <= 8) ? prm_cnt - 1 : 0;
            if (code >= CH_DIGIT0 && code <= CH_DIGIT9) begin
                p = prm[slot] * 10 + (code - CH_DIGIT0);
                prm[slot] = p > 65535 ? 65535 : p;
            end else if (code >= CH_SIXEL_LO && code <= CH_SIXEL_HI) begin
                if (parse_state == PM_REPEAT) begin
                    parse_state = PM_DATA;
                    has = paint_span(code - CH_SIXEL_LO, prm[0], sp);
                end else begin
                    if (parse_state == PM_COLOR) apply_color_request();
                    parse_state = PM_DATA;
                    has = paint_span(code - CH_SIXEL_LO, 1, sp);
                end
            end else if (code == CH_REPEAT || code == CH_COLOR) begin
                if (parse_state == PM_COLOR) apply_color_request();
                prm[0] = 0;
                prm_cnt = 1;
                parse_state = (code == CH_REPEAT) ? PM_REPEAT : PM_COLOR;
            end else if (code == CH_CR) begin
                cursor = 0;
            end else if (code == CH_NL) begin
                cursor = 0;
                band_top += 6;
                if (band_top >= eff_h()) begin
                    img_done = 1;
                    sp.iend = 1'b1;
                    has = 1;
                end
            end else if (code == CH_SEMI) begin
                if (prm_cnt < 8) begin
                    prm[prm_cnt] = 0;
                    prm_cnt++;
                end
            end
        end
        return has;
    endfunction

    // Input side: offer items, predict on each accepted transaction
    always @(posedge i_clk) begin
        span_cmd_t sp;
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (i_in_valid) begin
                items_in++;
                if (decode_item(cur_row.item, sp)) begin
                    if (cur_row.typed && sp != cur_row.span)
                        report($sformatf("predictor disagrees with table for byte %02h",
                                         cur_row.item.dbyte));
                    span_q.push_back(cur_row.typed ? cur_row.span : sp);
                end else if (cur_row.typed) begin
                    report($sformatf("table expects a span for byte %02h", cur_row.item.dbyte));
                end
            end
            if (stim_q.size() > 0 && $urandom_range(99) >= send_pct) begin
                cur_row = stim_q.pop_front();
                i_mode <= cur_row.item.mode;
                i_data_byte <= cur_row.item.dbyte;
                i_pal_index <= cur_row.item.idx;
                i_pal_value <= cur_row.item.val;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side stall, with one long hold-off while the sender keeps pushing
    always @(posedge i_clk) begin
        int hold_cnt;
        bit hold_done;
        if (phase_id == 2 && !hold_done && spans_out > 0) begin
            hold_cnt = 600;
            hold_done = 1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        span_cmd_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (span_q.size() == 0) begin
                report("result with nothing expected");
            end else begin
                e = span_q.pop_front();
                if (o_x_start !== e.x)
                    report($sformatf("x_start %0d, expected %0d", o_x_start, e.x));
                if (o_band_row !== e.row)
                    report($sformatf("band_row %0d, expected %0d", o_band_row, e.row));
                if (o_run_length !== e.run)
                    report($sformatf("run_length %0d, expected %0d", o_run_length, e.run));
                if (o_sixel_mask !== e.mask)
                    report($sformatf("sixel_mask %02h, expected %02h", o_sixel_mask, e.mask));
                if (o_paint_color !== e.color)
                    report($sformatf("paint_color %08h, expected %08h", o_paint_color, e.color));
                if (o_image_end !== e.iend)
                    report($sformatf("image_end %0b, expected %0b", o_image_end, e.iend));
                if (e.iend) image_ends++;
                else spans_out++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] mode, input logic [7:0] b,
                             input logic [7:0] idx, input logic [31:0] val);
        stim_row_t r;
        r = '0;
        r.item = '{mode: mode, dbyte: b, idx: idx, val: val};
        stim_q.push_back(r);
    endtask

    task automatic push_char(input logic [6:0] c);
        push_item(MODE_DATA, {1'($urandom_range(1)), c}, 8'($urandom), $urandom);
    endtask

    task automatic push_num(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        foreach (s[i]) push_char(7'(s[i]));
    endtask

    task automatic push_sixel();
        push_char(7'($urandom_range(CH_SIXEL_LO, CH_SIXEL_HI)));
    endtask

    task automatic push_typed(input logic [7:0] b, input logic [10:0] x,
                              input logic [10:0] row, input logic [11:0] run,
                              input logic [5:0] mask, input logic [31:0] color);
        stim_row_t r;
        r = '0;
        r.item = '{mode: MODE_DATA, dbyte: b, idx: 8'd0, val: 32'd0};
        r.typed = 1'b1;
        r.span = '{x: x, row: row, run: run, mask: mask, color: color, iend: 1'b0};
        stim_q.push_back(r);
    endtask

    // One well-formed or deliberately broken fragment of a sixel stream
    task automatic push_fragment();
        int r, k, nparm;
        r = $urandom_range(99);
        if (r < 28) begin
            repeat ($urandom_range(1, 4)) push_sixel();
        end else if (r < 42) begin
            push_char(CH_REPEAT);
            k = $urandom_range(9);
            if (k < 6) push_num($urandom_range(0, 20));
            else if (k < 9) push_num($urandom_range(0, 3000));
            else push_num($urandom_range(65530, 999999));
            push_sixel();
        end else if (r < 54) begin
            push_char(CH_COLOR);
            push_num($urandom_range(0, 300));
            push_sixel();
        end else if (r < 66) begin
            color_defs++;
            push_char(CH_COLOR);
            push_num($urandom_range(0, 300));
            k = $urandom_range(9);
            k = k < 4 ? KIND_HLS : (k < 8 ? KIND_RGB : $urandom_range(0, 9));
            push_char(CH_SEMI);
            push_num(k);
            nparm = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : 3;
            for (int i = 0; i < nparm; i++) begin
                push_char(CH_SEMI);
                if ($urandom_range(15) == 0) push_num($urandom_range(0, 70000));
                else if (i == 0 && k == KIND_HLS) push_num($urandom_range(0, 360));
                else push_num($urandom_range(0, 100));
            end
            if ($urandom_range(3) == 0) push_char(CH_COLOR);
            push_sixel();
        end else if (r < 72) begin
            push_char(CH_CR);
        end else if (r < 80) begin
            push_char(CH_NL);
        end else if (r < 84) begin
            push_item(MODE_DATA, 8'($urandom), 8'($urandom), $urandom);
        end else if (r < 88) begin
            push_item(MODE_PALWR, 8'($urandom), 8'($urandom), $urandom);
        end else if (r < 93) begin
            push_item(MODE_NEWIMG, 8'($urandom), 8'($urandom), $urandom);
        end else if (r < 95) begin
            push_item(MODE_UNUSED, 8'($urandom), 8'($urandom), $urandom);
        end else if (r < 97) begin
            push_char(CH_COLOR);
            push_num($urandom_range(0, 255));
            repeat ($urandom_range(8, 12)) push_char(CH_SEMI);
            push_sixel();
        end else begin
            push_char(CH_COLOR);
            push_num($urandom_range(0, 255));
            push_char(CH_REPEAT);
            push_num($urandom_range(0, 40));
            push_sixel();
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [11:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) reg_width = data;
        else if (idx == CFG_HEIGHT) reg_height = data;
        else if (idx == CFG_PALUSED) reg_palused = data & 12'h1FF;
    endtask

    task automatic wait_idle();
        while (stim_q.size() > 0 || i_in_valid || span_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    int unsigned cfg_sets [6][3] = '{
        '{2048, 2048, 256}, '{1, 6, 1}, '{100, 30, 17},
        '{4095, 2048, 0}, '{37, 12, 256}, '{2048, 1, 200}
    };

    initial begin
        int target;
        restart_image();
        foreach (pal_mem[i]) pal_mem[i] = 32'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bit 7 ignored, zero repeat, RGB define, band step, saturated repeat
        push_typed(8'hFE, 11'd0, 11'd0, 12'd1, 6'd63, 32'd0);
        push_char(CH_REPEAT);
        push_char(CH_DIGIT0);
        push_char(CH_SIXEL_HI);
        push_char(CH_COLOR);
        push_num(5);
        push_char(CH_SEMI);
        push_num(KIND_RGB);
        push_char(CH_SEMI);
        push_num(100);
        push_char(CH_SEMI);
        push_num(0);
        push_char(CH_SEMI);
        push_num(0);
        push_typed(8'h40, 11'd1, 11'd0, 12'd1, 6'd1, 32'hFF0000FF);
        push_char(CH_NL);
        push_char(CH_REPEAT);
        push_num(999999);
        push_typed(8'h7E, 11'd0, 11'd6, 12'd2048, 6'd63, 32'hFF0000FF);
        wait_idle();

        // Every palette entry gets a value before any random color select
        for (int i = 0; i < PAL_DEPTH; i++) push_item(MODE_PALWR, 8'($urandom), 8'(i), $urandom);
        wait_idle();

        for (int b = 0; b < 6; b++) begin
            phase_id = b / 2;
            send_pct = (phase_id == 0) ? 18 : (phase_id == 1 ? 75 : 0);
            recv_pct = (phase_id == 0) ? 75 : (phase_id == 1 ? 18 : 0);
            cfg_write(CFG_WIDTH, 12'(cfg_sets[b][0]));
            cfg_write(CFG_HEIGHT, 12'(cfg_sets[b][1]));
            cfg_write(CFG_PALUSED, 12'(cfg_sets[b][2]));
            push_item(MODE_NEWIMG, 8'd0, 8'd0, 32'd0);
            target = items_in + 1 + stim_q.size() + 130;
            while (items_in + stim_q.size() < target) push_fragment();
            wait_idle();
        end

        if (span_q.size() != 0) report($sformatf("%0d results never arrived", span_q.size()));
        $display("Covered %0d items, %0d spans, %0d image ends, %0d color definitions",
                 items_in, spans_out, image_ends, color_defs);
        $display("Six register settings across three stall patterns, %0d mismatches", errors);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
